[hdl/eoq_pkg.sv]
// ============================================================================
// Elevator order queue package
// Shared constants, types and helper functions for the elevator order queue.
// ============================================================================
package eoq_pkg;

    localparam int FLOOR_COUNT = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int FLOOR_W = 2;
    localparam int DIR_W   = 2;
    localparam int KIND_W  = 2;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 5;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Button kinds.
    localparam logic [KIND_W-1:0] KIND_CAB  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UP   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOWN = 2'd2;

    // Direction codes as stored and reported (two's complement).
    localparam logic [DIR_W-1:0] DIR_CAB  = 2'b00;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor;
        logic [DIR_W-1:0]   dir;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOKUP,
        ST_INSERT,
        ST_COMPACT,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic sweep;
        logic insert;
        logic commit;
        logic clear;
        logic publish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             exists;
        logic             sweep_done;
        logic             match;
        logic             out_free;
    } ctrl_sts_t;

    // Maps a button kind to its stored direction code.
    function automatic logic [DIR_W-1:0] kind_to_dir(input logic [KIND_W-1:0] kind);
        logic [DIR_W-1:0] dir;
        case (kind)
            KIND_UP:   dir = DIR_UP;
            KIND_DOWN: dir = DIR_DOWN;
            default:   dir = DIR_CAB;
        endcase
        return dir;
    endfunction

    // True when the building actually has this button.
    function automatic logic button_exists(input logic [KIND_W-1:0]  kind,
                                           input logic [FLOOR_W-1:0] floor);
        logic ok;
        ok = ({1'b0, floor} < (FLOOR_W + 1)'(FLOOR_COUNT));
        case (kind)
            KIND_CAB:  ok = ok;
            KIND_UP:   ok = ok && ({1'b0, floor} != (FLOOR_W + 1)'(FLOOR_COUNT - 1));
            KIND_DOWN: ok = ok && (floor != '0);
            default:   ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

[hdl/eoq_datapath.sv]
// ============================================================================
// Elevator order queue datapath
// Slot memory, count, sweep counters, head copy and the output register.
// ============================================================================
module eoq_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  eoq_pkg::ctrl_cmd_t            cmd,
    output eoq_pkg::ctrl_sts_t            sts,
    input  logic [eoq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [eoq_pkg::M_DATA_W-1:0]  m_tdata
);

    eoq_pkg::entry_t                    mem [eoq_pkg::QUEUE_DEPTH];

    logic [eoq_pkg::CMD_W-1:0]          cmd_reg;
    logic [eoq_pkg::KIND_W-1:0]         kind_reg;
    logic [eoq_pkg::FLOOR_W-1:0]        floor_reg;
    logic [eoq_pkg::CNT_W-1:0]          cnt_reg;
    logic [eoq_pkg::CNT_W-1:0]          rd_idx_reg;
    logic [eoq_pkg::CNT_W-1:0]          wr_idx_reg;
    logic                               pend_reg;
    logic                               match_reg;
    logic                               acc_reg;
    logic                               drop_reg;
    logic                               lamps_reg;
    logic                               m_valid_reg;
    eoq_pkg::entry_t                    rdata_reg;
    eoq_pkg::entry_t                    head_reg;
    logic [eoq_pkg::M_DATA_W-1:0]       m_data_reg;

    eoq_pkg::entry_t                    new_entry;
    eoq_pkg::entry_t                    head_out;
    logic                               is_arrive;
    logic                               rd_more;
    logic                               keep;
    logic                               full;
    logic                               comp_we;
    logic                               ins_we;
    logic [eoq_pkg::IDX_W-1:0]          waddr;
    eoq_pkg::entry_t                    wdata;
    logic                               head_nz;

    assign new_entry.floor = floor_reg;
    assign new_entry.dir   = eoq_pkg::kind_to_dir(kind_reg);
    assign is_arrive       = (cmd_reg == eoq_pkg::CMD_ARRIVE);
    assign rd_more         = (rd_idx_reg < cnt_reg);
    assign keep            = (rdata_reg.floor != floor_reg);
    assign full            = (cnt_reg >= eoq_pkg::CNT_W'(eoq_pkg::QUEUE_DEPTH));
    assign comp_we         = cmd.sweep && pend_reg && is_arrive && keep;
    assign ins_we          = cmd.insert && !full;
    assign waddr           = comp_we ? wr_idx_reg[eoq_pkg::IDX_W-1:0]
                                     : cnt_reg[eoq_pkg::IDX_W-1:0];
    assign wdata           = comp_we ? rdata_reg : new_entry;

    assign sts.command     = cmd_reg;
    assign sts.exists      = eoq_pkg::button_exists(kind_reg, floor_reg);
    assign sts.sweep_done  = !rd_more && !pend_reg;
    assign sts.match       = match_reg;
    assign sts.out_free    = !m_valid_reg || m_tready;

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (comp_we || ins_we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.sweep && rd_more)
        begin
            rdata_reg <= mem[rd_idx_reg[eoq_pkg::IDX_W-1:0]];
        end
    end

    // Captured command and head copy carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= s_tdata[1:0];
            kind_reg  <= s_tdata[3:2];
            floor_reg <= s_tdata[5:4];
        end
        if (comp_we && (wr_idx_reg == '0))
        begin
            head_reg <= rdata_reg;
        end
        else if (ins_we && (cnt_reg == '0))
        begin
            head_reg <= new_entry;
        end
        if (cmd.publish)
        begin
            m_data_reg <= {3'b000, eoq_pkg::COUNT_W'(cnt_reg), head_out.dir,
                           head_out.floor, head_nz, lamps_reg, drop_reg, acc_reg};
        end
    end

    assign head_nz  = (cnt_reg != '0);
    assign head_out = head_nz ? head_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            match_reg   <= 1'b0;
            acc_reg     <= 1'b0;
            drop_reg    <= 1'b0;
            lamps_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
                pend_reg   <= 1'b0;
                match_reg  <= 1'b0;
                acc_reg    <= 1'b0;
                drop_reg   <= 1'b0;
                lamps_reg  <= 1'b0;
            end
            if (cmd.sweep)
            begin
                pend_reg <= rd_more;
                if (rd_more)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                if (pend_reg && !is_arrive && (rdata_reg == new_entry))
                begin
                    match_reg <= 1'b1;
                end
                if (comp_we)
                begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                end
            end
            if (cmd.insert)
            begin
                if (full)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    acc_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                cnt_reg <= wr_idx_reg;
            end
            if (cmd.clear)
            begin
                cnt_reg   <= '0;
                lamps_reg <= 1'b1;
            end
            if (cmd.publish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[hdl/eoq_controller.sv]
// ============================================================================
// Elevator order queue controller
// Sequences one transaction through lookup, insertion or compaction.
// ============================================================================
module eoq_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  eoq_pkg::ctrl_sts_t  sts,
    output eoq_pkg::ctrl_cmd_t  cmd
);

    eoq_pkg::state_t state_reg;
    eoq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eoq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            eoq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = eoq_pkg::ST_DISPATCH;
                end
            end
            eoq_pkg::ST_DISPATCH:
            begin
                if (sts.command == eoq_pkg::CMD_BUTTON && sts.exists)
                begin
                    state_next = eoq_pkg::ST_LOOKUP;
                end
                else if (sts.command == eoq_pkg::CMD_ARRIVE)
                begin
                    state_next = eoq_pkg::ST_COMPACT;
                end
                else
                begin
                    state_next = eoq_pkg::ST_FINISH;
                end
            end
            eoq_pkg::ST_LOOKUP:
            begin
                if (sts.sweep_done)
                begin
                    state_next = sts.match ? eoq_pkg::ST_FINISH : eoq_pkg::ST_INSERT;
                end
            end
            eoq_pkg::ST_INSERT:
            begin
                state_next = eoq_pkg::ST_FINISH;
            end
            eoq_pkg::ST_COMPACT:
            begin
                if (sts.sweep_done)
                begin
                    state_next = eoq_pkg::ST_FINISH;
                end
            end
            eoq_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = eoq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eoq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            eoq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            eoq_pkg::ST_DISPATCH:
            begin
                cmd.clear = (sts.command == eoq_pkg::CMD_CLEAR);
            end
            eoq_pkg::ST_LOOKUP:
            begin
                cmd.sweep = 1'b1;
            end
            eoq_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
            end
            eoq_pkg::ST_COMPACT:
            begin
                cmd.sweep  = 1'b1;
                cmd.commit = sts.sweep_done;
            end
            eoq_pkg::ST_FINISH:
            begin
                cmd.publish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hdl/elevator_order_queue.sv]
// ============================================================================
// Elevator order queue
// Arrival-ordered table of elevator orders with duplicate suppression.
// ============================================================================
// A clear, an unknown command or a missing button goes straight from dispatch
// to the result; a lookup or an arrival first sweeps the valid slots, and an
// order that is appended or dropped takes an extra insert step after the lookup.
// Transactions are taken one at a time, each once the last has been published.
// Reset clears the order count and all handshake state; slot contents stay
// undefined until written and are never read before that.
module elevator_order_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input transactions.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] command, [3:2] button_kind, [5:4] floor_number, [7:6] zero.
    input  logic [eoq_pkg::S_DATA_W-1:0]  s_tdata,
    // Result transactions.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] order_accepted, [1] queue_full_drop, [2] lamps_all_off,
    // [3] head_valid, [5:4] head_floor, [7:6] head_direction,
    // [12:8] order_count, [15:13] zero.
    output logic [eoq_pkg::M_DATA_W-1:0]  m_tdata
);

    // The controller only sequences; every piece of state that describes the
    // queue lives in the datapath.
    eoq_pkg::ctrl_cmd_t cmd;
    eoq_pkg::ctrl_sts_t sts;

    eoq_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath sweeps the valid slots once per existing button (to find a
    // duplicate) or per arrival (compacting in place, since the write index
    // never passes the read index). The result sits in an output register so
    // that a new transaction can be taken while it waits.
    eoq_datapath u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/eoq_checker.sv]
// ============================================================================
// Elevator order queue checker
// Port-level checks on results of the elevator order queue.
// ============================================================================
module eoq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic [15:0] m_tdata
);

    // A transaction never enters and is dropped at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("order both accepted and dropped");

    // The head is valid exactly when orders are queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tdata[12:8] != 5'd0)))
        else $error("head valid disagrees with count");

    // An empty table reports a zero head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[3]) |-> (m_tdata[7:4] == 4'd0))
        else $error("head fields not zero on empty table");

    // A clear leaves the table empty and enters no order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[12:8] == 5'd0 && !m_tdata[0]))
        else $error("clear left orders behind");

    // One transaction at a time: input is refused right after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while busy");

endmodule

bind elevator_order_queue eoq_checker u_eoq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
);
